// ----- hdl/longest_prefix_match_table_macros.svh -----
// Assertion macros shared by the route table checkers.
`ifndef LONGEST_PREFIX_MATCH_TABLE_MACROS_SVH
`define LONGEST_PREFIX_MATCH_TABLE_MACROS_SVH

// Checked on every rising edge of clk, ignored while reset is active.
`define LPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, including during reset.
`define LPM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/lpm_pkg.sv -----
// Package with the types, sizes and merge function of the route table.
package lpm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int PORT_COUNT  = 4;

  localparam int ADDR_W = 32;
  localparam int PORT_W = 2;
  localparam int IDX_W  = 4;

  // The compare tree is padded up to a power of two.
  localparam int LOG_DEPTH = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEAVES    = 1 << LOG_DEPTH;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  // One candidate route; an empty candidate carries all-zero fields.
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gw;
    logic [PORT_W-1:0] port;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  typedef cand_t [LEAVES-1:0] cand_vec_t;

  // Table write request from the input stage.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gw;
    logic [PORT_W-1:0] port;
    logic              valid;
  } wr_req_t;

  // Pipeline control toward the compare tree.
  typedef struct packed {
    logic advance;
    logic lookup_vld;
  } pipe_ctl_t;

  // The lower-index candidate is lo. A longer or equal mask on the higher
  // index wins, so ties go to the higher slot.
  function automatic cand_t lpm_merge(cand_t lo, cand_t hi);
    cand_t res;
    if (hi.found && (!lo.found || (hi.mask >= lo.mask))) begin
      res = hi;
    end else begin
      res = lo;
    end
    return res;
  endfunction

endpackage

// ----- hdl/lpm_table.sv -----
// Route entry storage with a per-entry prefix compare for lookups.
module lpm_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpm_pkg::wr_req_t            wr_i,
  input  logic [lpm_pkg::ADDR_W-1:0]  addr_i,
  output lpm_pkg::cand_vec_t          leaf_o
);
  import lpm_pkg::*;

  logic [ADDR_W-1:0] prefix_r [TABLE_DEPTH];
  logic [ADDR_W-1:0] mask_r   [TABLE_DEPTH];
  logic [ADDR_W-1:0] gw_r     [TABLE_DEPTH];
  logic [PORT_W-1:0] port_r   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TABLE_DEPTH-1:0] match_w;

  for (genvar i = 0; i < LEAVES; i++) begin : g_entry
    if (i < TABLE_DEPTH) begin : g_real
      logic we_w;

      // An index at or above the table depth selects no entry.
      assign we_w = wr_i.en && (32'(wr_i.index) == i);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[i] <= 1'b0;
        end else if (we_w) begin
          valid_r[i] <= wr_i.valid;
        end
      end

      always_ff @(posedge clk) begin
        if (we_w) begin
          prefix_r[i] <= wr_i.prefix;
          mask_r[i]   <= wr_i.mask;
          gw_r[i]     <= wr_i.gw;
          port_r[i]   <= wr_i.port;
        end
      end

      assign match_w[i] = valid_r[i] && (((addr_i ^ prefix_r[i]) & mask_r[i]) == '0);

      assign leaf_o[i] = match_w[i]
                       ? cand_t'{found: 1'b1, mask: mask_r[i], gw: gw_r[i],
                                 port: port_r[i], idx: IDX_W'(i)}
                       : cand_t'('0);
    end else begin : g_pad
      assign leaf_o[i] = cand_t'('0);
    end
  end

endmodule

// ----- hdl/lpm_tree.sv -----
// Registered binary tree that picks the longest matching route.
module lpm_tree (
  input  logic                clk,
  input  logic                rst_n,
  input  lpm_pkg::pipe_ctl_t  ctl_i,
  input  lpm_pkg::cand_vec_t  leaf_i,
  output lpm_pkg::cand_t      root_o,
  output logic                vld_o
);
  import lpm_pkg::*;

  // Heap layout: node k has children 2k and 2k+1, node 1 is the root.
  cand_t node_r [1:LEAVES-1];
  logic [LOG_DEPTH:1] vld_r;

  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    cand_t lo_w;
    cand_t hi_w;

    if (2 * k >= LEAVES) begin : g_from_leaf
      assign lo_w = leaf_i[2 * k - LEAVES];
      assign hi_w = leaf_i[2 * k + 1 - LEAVES];
    end else begin : g_from_node
      assign lo_w = node_r[2 * k];
      assign hi_w = node_r[2 * k + 1];
    end

    always_ff @(posedge clk) begin
      if (ctl_i.advance) begin
        node_r[k] <= lpm_merge(lo_w, hi_w);
      end
    end
  end

  // One valid bit per tree level; level one sits right after the leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl_i.advance) begin
      vld_r[1] <= ctl_i.lookup_vld;
      for (int j = 2; j <= LOG_DEPTH; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  assign root_o = node_r[1];
  assign vld_o  = vld_r[LOG_DEPTH];

endmodule

// ----- hdl/longest_prefix_match_table.sv -----
// Usage: IPv4 route table with longest-prefix lookup, top level.
//
// Input channel (in_*): one transaction either writes a route entry
// (in_opcode write: prefix on in_address, mask, gateway, port, valid bit)
// or looks up in_address. Writes give no result; each lookup gives one
// result transaction on the out_* channel, in order.
// A result carries the hit flag and the gateway, port and slot of the
// matching entry with the longest mask; a tie goes to the higher slot.
// On a miss all result fields are zero.
// Pipeline: a lookup passes one input stage, then the compare tree, which
// registers each of its levels; the result is valid at the tree root.
// Throughput: one transaction per cycle unless the receiver stalls, reads
// and writes mixed freely; a lookup sees every write accepted before it.
// When the receiver stalls, the whole pipeline holds and in_ready drops;
// nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all entry valid bits and empties
// the pipeline.
module longest_prefix_match_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [lpm_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [lpm_pkg::ADDR_W-1:0]  in_address,
  input  logic [lpm_pkg::ADDR_W-1:0]  in_entry_mask,
  input  logic [lpm_pkg::ADDR_W-1:0]  in_entry_gateway,
  input  logic [lpm_pkg::PORT_W-1:0]  in_entry_port,
  input  logic                        in_entry_valid,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [lpm_pkg::ADDR_W-1:0]  out_next_hop,
  output logic [lpm_pkg::PORT_W-1:0]  out_out_port,
  output logic [lpm_pkg::IDX_W-1:0]   out_matched_index
);
  import lpm_pkg::*;

  logic              advance_w;
  logic              a_vld_r;
  logic              a_op_r;
  logic [IDX_W-1:0]  a_index_r;
  logic [ADDR_W-1:0] a_addr_r;
  logic [ADDR_W-1:0] a_mask_r;
  logic [ADDR_W-1:0] a_gw_r;
  logic [PORT_W-1:0] a_port_r;
  logic              a_valid_r;
  logic [PORT_W-1:0] port_clamp_w;
  wr_req_t           wr_w;
  pipe_ctl_t         ctl_w;
  cand_vec_t         leaf_w;
  cand_t             root_w;
  logic              root_vld_w;

  assign advance_w = !root_vld_w || out_ready;
  assign in_ready  = advance_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (advance_w) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_w) begin
      a_op_r    <= in_opcode;
      a_index_r <= in_entry_index;
      a_addr_r  <= in_address;
      a_mask_r  <= in_entry_mask;
      a_gw_r    <= in_entry_gateway;
      a_port_r  <= in_entry_port;
      a_valid_r <= in_entry_valid;
    end
  end

  // A port number beyond the last interface is stored as the last one.
  assign port_clamp_w = (int'(a_port_r) >= PORT_COUNT) ? PORT_W'(PORT_COUNT - 1) : a_port_r;

  // Writes commit as they leave the input stage, so a lookup behind them
  // compares against the updated table.
  assign wr_w = '{en:     advance_w && a_vld_r && (a_op_r == OP_WRITE),
                  index:  a_index_r,
                  prefix: a_addr_r,
                  mask:   a_mask_r,
                  gw:     a_gw_r,
                  port:   port_clamp_w,
                  valid:  a_valid_r};

  assign ctl_w = '{advance:    advance_w,
                   lookup_vld: a_vld_r && (a_op_r == OP_LOOKUP)};

  lpm_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_i   (wr_w),
    .addr_i (a_addr_r),
    .leaf_o (leaf_w)
  );

  lpm_tree u_tree (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_w),
    .leaf_i (leaf_w),
    .root_o (root_w),
    .vld_o  (root_vld_w)
  );

  assign out_valid         = root_vld_w;
  assign out_hit           = root_w.found;
  assign out_next_hop      = root_w.gw;
  assign out_out_port      = root_w.port;
  assign out_matched_index = root_w.idx;

endmodule

// ----- hdl/lpm_checker.sv -----
// Port-level checker for the route table, bound to the top level.
`include "longest_prefix_match_table_macros.svh"

module lpm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_hit,
  input logic [lpm_pkg::ADDR_W-1:0]  out_next_hop,
  input logic [lpm_pkg::PORT_W-1:0]  out_out_port,
  input logic [lpm_pkg::IDX_W-1:0]   out_matched_index
);
  import lpm_pkg::*;

  logic                             out_stall_w;
  logic [ADDR_W+PORT_W+IDX_W:0]     out_payload_w;

  assign out_stall_w   = out_valid && !out_ready;
  assign out_payload_w = {out_hit, out_next_hop, out_out_port, out_matched_index};

  // A stalled result transaction stays offered.
  `LPM_ASSERT(a_out_hold, out_stall_w |=> out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `LPM_ASSERT(a_out_stable, out_stall_w |=> $stable(out_payload_w), "result changed while stalled")

  // A miss reports all-zero route fields.
  `LPM_ASSERT(a_miss_zero, out_valid && !out_hit |-> out_payload_w == '0, "miss with nonzero fields")

  // The input side only waits on a stalled result.
  `LPM_ASSERT(a_ready_free, !out_valid |-> in_ready, "input stalled without pending result")

  // Reset empties the pipeline.
  `LPM_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result offered right after reset")

endmodule

bind longest_prefix_match_table lpm_checker u_lpm_checker (.*);
